// ----- hw/rtl/deq_pkg.sv -----
// Package for the double-ended queue with search.
// Holds the payload widths, operation and status codes, and the cell control struct.
// No dependencies.
`default_nettype none

package deq_pkg;

    localparam int KIND_W      = 3;
    localparam int VALUE_W     = 32;
    localparam int POPPED_W    = 32;
    localparam int STATUS_W    = 2;

    localparam int DEPTH_DEF   = 16;
    localparam int DATA_W_DEF  = 32;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push_front;  // shift toward the back, cell 0 takes the new word
        logic push_back;   // first free cell takes the new word
        logic pop_front;   // shift toward the front
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/deq_in_if.sv -----
// Input channel of the queue: valid/ready plus operation code and word.
// Depends on deq_pkg.
`default_nettype none

interface deq_in_if;
    logic                         valid;
    logic                         ready;
    logic [deq_pkg::KIND_W-1:0]   kind;
    logic [deq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/deq_out_if.sv -----
// Result channel of the queue: valid/ready plus popped word, found flag, status.
// Depends on deq_pkg.
`default_nettype none

interface deq_out_if;
    logic                          valid;
    logic                          ready;
    logic [deq_pkg::POPPED_W-1:0]  popped;
    logic                          found;
    logic [deq_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output popped, output found, output status, input ready);
    modport sink   (input valid, input popped, input found, input status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/deq_cell.sv -----
// One storage cell of the queue chain: holds a word, shifts with its neighbors,
// compares against the search word. Depends on deq_pkg.
`default_nettype none

module deq_cell #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_W_DEF,
    parameter int INDEX      = 0,
    localparam int OCC_W     = $clog2(DEPTH + 1)
) (
    input  wire                   i_clk,
    input  wire deq_pkg::t_cell_ctl i_ctl,
    input  wire [OCC_W-1:0]       i_occ,
    input  wire [DATA_WIDTH-1:0]  i_value,
    input  wire [DATA_WIDTH-1:0]  i_left_data,   // from cell INDEX-1 (new word at cell 0)
    input  wire [DATA_WIDTH-1:0]  i_right_data,  // from cell INDEX+1 (own word at the last cell)
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_tail,        // own word if this is the last occupied cell
    output logic                  o_hit
);

    localparam logic [OCC_W-1:0] IDX      = OCC_W'(INDEX);
    localparam logic [OCC_W-1:0] IDX_NEXT = OCC_W'(INDEX + 1);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_occupied;

    assign w_occupied = (IDX < i_occ);

    always_comb begin
        n_data = r_data;
        if (i_ctl.push_front) begin
            n_data = i_left_data;
        end else if (i_ctl.pop_front) begin
            n_data = i_right_data;
        end else if (i_ctl.push_back && (i_occ == IDX)) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tail = (i_occ == IDX_NEXT) ? r_data : '0;
    assign o_hit  = w_occupied && (r_data == i_value);

endmodule

`default_nettype wire

// ----- hw/rtl/double_ended_queue_with_search.sv -----
// Bounded double-ended queue with membership search.
//
// Channels: i_in (sink) carries one beat per operation: kind (push front,
// push back, pop front, pop back, search) and a 32-bit value. o_out (source)
// returns exactly one beat per accepted operation: popped word (zero unless a
// pop succeeded), found flag (search only) and status (done, pop on empty,
// push on full). Undefined kinds return an all-zero result and change nothing.
//
// Structure: DEPTH identical cells in a row; the front of the queue is always
// cell 0 and entries fill cells 0..occupancy-1. Push front shifts every cell
// one place back, pop front shifts one place forward, push back writes the
// first free cell, pop back just drops the count. Every occupied cell compares
// its word with the search value in the same cycle.
//
// Timing: the result is registered and appears in the cycle after acceptance.
// i_in.ready is high whenever the result register is empty or being drained,
// so one beat per cycle is sustained while the receiver keeps ready high.
// When the receiver stalls, the result holds and i_in.ready drops until the
// pending beat is taken; no beats are lost or repeated.
//
// Reset (synchronous, i_rst_n low) empties the queue and clears the result
// register; cell contents are not cleared and are never read until written.
`default_nettype none

module double_ended_queue_with_search #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_W_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    deq_in_if.sink      i_in,
    deq_out_if.source   o_out
);

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [OCC_W-1:0] FULL_CNT = OCC_W'(DEPTH);
    localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

    // occupancy and result register
    logic [OCC_W-1:0]                 r_occ;
    logic [OCC_W-1:0]                 n_occ;
    logic                             r_out_valid;
    logic [deq_pkg::POPPED_W-1:0]     r_popped;
    logic                             r_found;
    logic [deq_pkg::STATUS_W-1:0]     r_status;

    logic                             w_accept;
    logic                             w_full;
    logic                             w_empty;
    deq_pkg::t_cell_ctl               w_ctl;
    logic [DATA_WIDTH-1:0]            w_value;
    logic [DATA_WIDTH-1:0]            w_pop_word;
    logic [deq_pkg::POPPED_W-1:0]     w_pop_trunc;
    logic [deq_pkg::POPPED_W-1:0]     n_popped;
    logic                             n_found;
    logic [deq_pkg::STATUS_W-1:0]     n_status;

    // cell row
    logic [DATA_WIDTH-1:0]            w_data [DEPTH];
    logic [DATA_WIDTH-1:0]            w_tail [DEPTH];
    logic [DEPTH-1:0]                 w_hit;
    logic [DATA_WIDTH-1:0]            w_tail_or;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_full   = (r_occ == FULL_CNT);
    assign w_empty  = (r_occ == '0);

    // input word taken to the stored width
    generate
        if (DATA_WIDTH >= deq_pkg::VALUE_W) begin : g_val_ext
            assign w_value = DATA_WIDTH'(i_in.value);
        end else begin : g_val_trunc
            assign w_value = i_in.value[DATA_WIDTH-1:0];
        end
    endgenerate

    // command decode
    always_comb begin
        w_ctl    = '0;
        n_occ    = r_occ;
        n_found  = 1'b0;
        n_status = deq_pkg::ST_DONE;
        w_pop_word = '0;
        unique case (i_in.kind)
            deq_pkg::KIND_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    w_ctl.push_front = w_accept;
                    n_occ = r_occ + OCC_ONE;
                end
            end
            deq_pkg::KIND_PUSH_BACK: begin
                if (w_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    w_ctl.push_back = w_accept;
                    n_occ = r_occ + OCC_ONE;
                end
            end
            deq_pkg::KIND_POP_FRONT: begin
                if (w_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    w_ctl.pop_front = w_accept;
                    w_pop_word = w_data[0];
                    n_occ = r_occ - OCC_ONE;
                end
            end
            deq_pkg::KIND_POP_BACK: begin
                if (w_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    w_pop_word = w_tail_or;
                    n_occ = r_occ - OCC_ONE;
                end
            end
            deq_pkg::KIND_SEARCH: begin
                n_found = |w_hit;
            end
            default: begin
            end
        endcase
    end

    generate
        if (DATA_WIDTH >= deq_pkg::POPPED_W) begin : g_pop_trunc
            assign w_pop_trunc = w_pop_word[deq_pkg::POPPED_W-1:0];
        end else begin : g_pop_ext
            assign w_pop_trunc = deq_pkg::POPPED_W'(w_pop_word);
        end
    endgenerate
    assign n_popped = w_pop_trunc;

    // the row of cells
    generate
        for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = w_value;
            end else begin : g_mid_l
                assign w_left = w_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_right = w_data[gi];
            end else begin : g_mid_r
                assign w_right = w_data[gi+1];
            end
            deq_cell #(
                .DEPTH      (DEPTH),
                .DATA_WIDTH (DATA_WIDTH),
                .INDEX      (gi)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_occ        (r_occ),
                .i_value      (w_value),
                .i_left_data  (w_left),
                .i_right_data (w_right),
                .o_data       (w_data[gi]),
                .o_tail       (w_tail[gi]),
                .o_hit        (w_hit[gi])
            );
        end
    endgenerate

    // only the last occupied cell drives a nonzero tail word
    always_comb begin
        w_tail_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_tail_or = w_tail_or | w_tail[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_occ       <= n_occ;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped <= n_popped;
            r_found  <= n_found;
            r_status <= n_status;
        end
    end

    assign i_in.ready    = !r_out_valid || o_out.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.popped  = r_popped;
    assign o_out.found   = r_found;
    assign o_out.status  = r_status;

endmodule

`default_nettype wire

// ----- hw/rtl/deq_checker.sv -----
// Port-level checks for the double-ended queue with search, plus its bind.
// Depends on deq_pkg and double_ended_queue_with_search.
`default_nettype none

module deq_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_in_valid,
    input wire                           i_in_ready,
    input wire                           i_out_valid,
    input wire                           i_out_ready,
    input wire [deq_pkg::POPPED_W-1:0]   i_out_popped,
    input wire                           i_out_found,
    input wire [deq_pkg::STATUS_W-1:0]   i_out_status
);

    // every accepted beat shows up as a result on the next cycle
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted beat produced no result");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_popped) && $stable(i_out_found)
             && $stable(i_out_status)))
        else $error("stalled result changed");

    // an error result carries no word and no found flag
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status != deq_pkg::ST_DONE) |->
            (i_out_popped == '0 && !i_out_found))
        else $error("error result carries data");

    // found comes only from a search, which pops nothing
    a_found_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_found) |->
            (i_out_popped == '0 && i_out_status == deq_pkg::ST_DONE))
        else $error("found set on a non-search result");

    // result register is empty after a reset edge
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind double_ended_queue_with_search deq_checker u_deq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_popped (o_out.popped),
    .i_out_found  (o_out.found),
    .i_out_status (o_out.status)
);

`default_nettype wire
